>>> rtl/core/rpsd_pkg.sv
`default_nettype none

package rpsd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] HDR_RUN_FLAG = 8'h80;
  localparam logic [7:0] HDR_LEN_MASK = 8'h7F;

  typedef enum logic [2:0] {
    PhHeader = 3'b001,
    PhLow    = 3'b010,
    PhHigh   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_end;
    logic        truncated;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/rpsd_front.sv
`default_nettype none

module rpsd_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   fire_i,
  input  wire  [7:0]            stream_byte_i,
  input  wire                   stream_end_i,
  output logic                  push_o,
  output rpsd_pkg::result_t     push_data_o
);

  rpsd_pkg::phase_e phase_q, phase_d;
  logic             run_q, run_d;
  logic [7:0]       count_q, count_d;
  logic [7:0]       low_q, low_d;
  logic [15:0]      pix;
  logic [7:0]       cnt;
  logic             done;

  always_comb begin
    phase_d     = phase_q;
    run_d       = run_q;
    count_d     = count_q;
    low_d       = low_q;
    push_o      = 1'b0;
    push_data_o = '0;
    pix         = {stream_byte_i, low_q};
    cnt         = 8'd1;
    done        = 1'b1;
    if (fire_i) begin
      case (phase_q)
        rpsd_pkg::PhLow: begin
          low_d   = stream_byte_i;
          phase_d = rpsd_pkg::PhHigh;
          if (stream_end_i) begin
            phase_d = rpsd_pkg::PhHeader;
            run_d   = 1'b0;
            count_d = '0;
            push_o  = 1'b1;
            push_data_o.image_end = 1'b1;
            push_data_o.truncated = 1'b1;
          end
        end
        rpsd_pkg::PhHigh: begin
          if (run_q) begin
            cnt  = count_q;
            done = 1'b1;
          end else begin
            cnt  = 8'd1;
            done = (count_q <= 8'd1);
          end
          push_o = 1'b1;
          if (stream_end_i || done) begin
            phase_d = rpsd_pkg::PhHeader;
            run_d   = 1'b0;
            count_d = '0;
          end else begin
            phase_d = rpsd_pkg::PhLow;
            count_d = count_q - 8'd1;
          end
          if (stream_end_i && !done) begin
            push_data_o.image_end = 1'b1;
            push_data_o.truncated = 1'b1;
          end else begin
            push_data_o.pixel_value  = pix;
            push_data_o.repeat_count = cnt;
            push_data_o.image_end    = stream_end_i;
          end
        end
        default: begin
          run_d = (stream_byte_i & rpsd_pkg::HDR_RUN_FLAG) != '0;
          if (run_d) begin
            count_d = (stream_byte_i & rpsd_pkg::HDR_LEN_MASK) + 8'd1;
          end else begin
            count_d = stream_byte_i + 8'd1;
          end
          phase_d = rpsd_pkg::PhLow;
          if (stream_end_i) begin
            phase_d = rpsd_pkg::PhHeader;
            run_d   = 1'b0;
            count_d = '0;
            push_o  = 1'b1;
            push_data_o.image_end = 1'b1;
            push_data_o.truncated = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rpsd_pkg::PhHeader;
      run_q   <= 1'b0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      run_q   <= run_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q <= low_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/rpsd_queue.sv
`default_nettype none

module rpsd_queue #(
  parameter int unsigned Depth = rpsd_pkg::QUEUE_DEPTH
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  rpsd_pkg::result_t     push_data_i,
  input  wire                   pop_i,
  output logic                  full_o,
  output logic                  valid_o,
  output rpsd_pkg::result_t     rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rpsd_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o    = (cnt_q == FullCnt);
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rpsd_back.sv
`default_nettype none

module rpsd_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   q_valid_i,
  input  rpsd_pkg::result_t     q_data_i,
  output logic                  q_pop_o,
  input  wire                   out_ready_i,
  output logic                  out_valid_o,
  output rpsd_pkg::result_t     out_data_o
);

  logic              valid_q, valid_d;
  rpsd_pkg::result_t data_q;

  assign q_pop_o     = q_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    if (q_pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_q <= q_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rle_pixel_stream_decoder.sv
// Run-length decoder for a byte stream of 16-bit pixels.
// Input channel: one compressed byte per transaction (stream_byte_i), with
// stream_end_i flagging the last byte of the image; valid/ready handshake.
// Output channel: run descriptors (pixel_value_o, repeat_count_o) with
// image_end_o on the descriptor caused by the last byte and truncated_o
// when the image ended inside an unfinished token; valid/ready handshake.
// Header and low-byte transactions produce no descriptor unless flagged last.
// Throughput: one input byte per cycle, sustained while the queue is not full.
// Path: the parser is combinational and writes the queue at the edge that
// accepts the byte completing a descriptor; out_valid_o rises when the
// output register takes that descriptor from the queue.
// The parser writes into a QueueDepth-entry queue; the output register
// drains it. When the receiver stalls the queue fills, and in_ready_o drops
// only once the queue is full.
// Reset: parser returns to expecting a header byte, queue and output
// register are emptied; no clearing sweep is needed.
`default_nettype none

module rle_pixel_stream_decoder #(
  parameter int unsigned QueueDepth = rpsd_pkg::QUEUE_DEPTH
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire  [7:0]   stream_byte_i,
  input  wire          stream_end_i,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output logic [15:0]  pixel_value_o,
  output logic [7:0]   repeat_count_o,
  output logic         image_end_o,
  output logic         truncated_o
);

  logic              fire;
  logic              push;
  rpsd_pkg::result_t push_data;
  logic              q_full;
  logic              q_valid;
  rpsd_pkg::result_t q_data;
  logic              q_pop;
  rpsd_pkg::result_t out_data;

  assign in_ready_o = !q_full;
  assign fire       = in_valid_i && in_ready_o;

  rpsd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .stream_byte_i (stream_byte_i),
    .stream_end_i  (stream_end_i),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  rpsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .rd_data_o   (q_data)
  );

  rpsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data)
  );

  assign pixel_value_o  = out_data.pixel_value;
  assign repeat_count_o = out_data.repeat_count;
  assign image_end_o    = out_data.image_end;
  assign truncated_o    = out_data.truncated;

`ifndef SYNTHESIS
  a_trunc_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && truncated_o |->
      image_end_o && repeat_count_o == 8'd0 && pixel_value_o == 16'd0)
    else $error("truncation descriptor malformed");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !truncated_o |-> repeat_count_o != 8'd0)
    else $error("zero repeat count on a pixel descriptor");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> repeat_count_o <= 8'd128)
    else $error("repeat count above 128");
`endif

endmodule

`default_nettype wire

>>> tb/sv/rle_pixel_stream_decoder_tb.sv
class run_descriptor_predictor;
  rpsd_pkg::phase_e    phase;
  logic                run_mode;
  logic [7:0]          count_left;
  logic [7:0]          low_hold;
  rpsd_pkg::result_t   pending_runs[$];
  int                  mismatches;
  int                  n_bytes;
  int                  n_runs;
  int                  n_image_ends;
  int                  n_truncations;
  int                  n_max_runs;

  function new();
    restart();
    mismatches    = 0;
    n_bytes       = 0;
    n_runs        = 0;
    n_image_ends  = 0;
    n_truncations = 0;
    n_max_runs    = 0;
  endfunction

  function void restart();
    phase      = rpsd_pkg::PhHeader;
    run_mode   = 1'b0;
    count_left = 8'd0;
    low_hold   = 8'd0;
  endfunction

  function int pending();
    return pending_runs.size();
  endfunction

  // Input transaction accepted: advance the token parser, queue any descriptor.
  function void note_byte(logic [7:0] b, logic last);
    rpsd_pkg::result_t r;
    logic [15:0]       pix;
    logic [7:0]        cnt;
    logic              done;
    r = '0;
    n_bytes++;
    case (phase)
      rpsd_pkg::PhLow: begin
        low_hold = b;
        phase    = rpsd_pkg::PhHigh;
        if (last) begin
          restart();
          r.image_end = 1'b1;
          r.truncated = 1'b1;
          pending_runs.push_back(r);
        end
      end
      rpsd_pkg::PhHigh: begin
        pix = {b, low_hold};
        if (run_mode) begin
          cnt  = count_left;
          done = 1'b1;
        end else begin
          cnt = 8'd1;
          if (count_left <= 8'd1) begin
            done       = 1'b1;
            count_left = 8'd0;
          end else begin
            done       = 1'b0;
            count_left = count_left - 8'd1;
          end
        end
        if (last) begin
          restart();
          r.image_end = 1'b1;
          if (done) begin
            r.pixel_value  = pix;
            r.repeat_count = cnt;
          end else begin
            r.truncated = 1'b1;
          end
        end else begin
          if (done) begin
            restart();
          end else begin
            phase = rpsd_pkg::PhLow;
          end
          r.pixel_value  = pix;
          r.repeat_count = cnt;
        end
        pending_runs.push_back(r);
      end
      default: begin
        run_mode = ((b & rpsd_pkg::HDR_RUN_FLAG) != 8'd0);
        if (run_mode) begin
          count_left = (b & rpsd_pkg::HDR_LEN_MASK) + 8'd1;
        end else begin
          count_left = b + 8'd1;
        end
        phase = rpsd_pkg::PhLow;
        if (last) begin
          restart();
          r.image_end = 1'b1;
          r.truncated = 1'b1;
          pending_runs.push_back(r);
        end
      end
    endcase
  endfunction

  function bit report_next();
    mismatches++;
    return mismatches <= 10;
  endfunction

  // Output transaction accepted: compare against the oldest queued descriptor.
  function void check_run(rpsd_pkg::result_t got);
    rpsd_pkg::result_t want;
    if (pending_runs.size() == 0) begin
      if (report_next()) begin
        $display("ERROR: unexpected descriptor pix=%h cnt=%0d end=%b trunc=%b",
                 got.pixel_value, got.repeat_count, got.image_end, got.truncated);
      end
      return;
    end
    want = pending_runs.pop_front();
    n_runs++;
    if (want.image_end) n_image_ends++;
    if (want.truncated) n_truncations++;
    if (want.repeat_count == 8'd128) n_max_runs++;
    if (got.pixel_value !== want.pixel_value || got.repeat_count !== want.repeat_count ||
        got.image_end !== want.image_end || got.truncated !== want.truncated) begin
      if (report_next()) begin
        $display("ERROR: descriptor %0d: expected pix=%h cnt=%0d end=%b trunc=%b, got pix=%h cnt=%0d end=%b trunc=%b",
                 n_runs, want.pixel_value, want.repeat_count, want.image_end, want.truncated,
                 got.pixel_value, got.repeat_count, got.image_end, got.truncated);
      end
    end
  endfunction
endclass

module rle_pixel_stream_decoder_tb;

  localparam int QuietLimit  = 4000;
  localparam int RandomBytes = 400;

  typedef enum int {RdyAlways, RdyHalf, RdySparse, RdyMostly} ready_mode_e;
  typedef enum int {TokOpen, TokClose, TokCut} token_end_e;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  stream_byte  = 8'd0;
  logic        stream_end   = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [15:0] pixel_value;
  logic [7:0]  repeat_count;
  logic        image_end;
  logic        truncated;

  run_descriptor_predictor runs = new();

  ready_mode_e ready_mode  = RdyAlways;
  int          ready_hold  = 0;
  int          quiet_cycles = 0;
  int          burst_left  = 0;
  int          bytes_fed   = 0;

  rle_pixel_stream_decoder u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .stream_byte_i  (stream_byte),
    .stream_end_i   (stream_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pixel_value_o  (pixel_value),
    .repeat_count_o (repeat_count),
    .image_end_o    (image_end),
    .truncated_o    (truncated)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      runs.note_byte(stream_byte, stream_end);
    end
    if (out_valid && out_ready) begin
      runs.check_run({pixel_value, repeat_count, image_end, truncated});
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver backpressure: switches at random between stall patterns.
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      ready_hold <= $urandom_range(16, 96);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      RdyAlways: out_ready <= 1'b1;
      RdyHalf:   out_ready <= ($urandom_range(0, 1) == 0);
      RdySparse: out_ready <= ($urandom_range(0, 5) == 0);
      default:   out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic feed_byte(input logic [7:0] b, input logic last);
    int gap;
    in_valid    <= 1'b1;
    stream_byte <= b;
    stream_end  <= last;
    do @(posedge clk); while (!in_ready);
    bytes_fed++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 10);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (runs.pending() > 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_pixel_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic feed_token(input token_end_e how);
    logic [7:0] seq[$];
    logic [7:0] hdr;
    int         npix;
    int         stop;
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0:       hdr = rpsd_pkg::HDR_RUN_FLAG;
        1:       hdr = rpsd_pkg::HDR_RUN_FLAG | rpsd_pkg::HDR_LEN_MASK;
        default: hdr = rpsd_pkg::HDR_RUN_FLAG | 8'($urandom_range(0, 127));
      endcase
      npix = 1;
    end else begin
      hdr  = ($urandom_range(0, 49) == 0) ? rpsd_pkg::HDR_LEN_MASK : 8'($urandom_range(0, 6));
      npix = int'(hdr) + 1;
    end
    seq.push_back(hdr);
    repeat (npix) begin
      seq.push_back(pick_pixel_byte());
      seq.push_back(pick_pixel_byte());
    end
    stop = seq.size() - 1;
    if (how == TokCut) stop = $urandom_range(0, seq.size() - 2);
    for (int i = 0; i <= stop; i++) begin
      feed_byte(seq[i], (how != TokOpen) && (i == stop));
    end
  endtask

  // {final flag, byte}
  logic [8:0] directed[25] = '{
    {1'b0, 8'h80}, {1'b0, 8'h00}, {1'b0, 8'h00},
    {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF},
    {1'b0, 8'h01}, {1'b0, 8'h34}, {1'b0, 8'h12}, {1'b0, 8'hCD}, {1'b0, 8'hAB},
    {1'b1, 8'h7F},
    {1'b0, 8'h85}, {1'b1, 8'h55},
    {1'b0, 8'h01}, {1'b0, 8'h11}, {1'b0, 8'h22}, {1'b0, 8'h33}, {1'b1, 8'h44},
    {1'b0, 8'h02}, {1'b0, 8'hAA}, {1'b1, 8'h55},
    {1'b0, 8'h83}, {1'b0, 8'h00}, {1'b1, 8'h80}
  };

  initial begin : watchdog
    do @(posedge clk); while (quiet_cycles < QuietLimit);
    $display("ERROR: no transaction for %0d cycles", QuietLimit);
    $display("rle_pixel_stream_decoder_tb failed");
    $finish;
  end

  initial begin : stimulus
    int pick;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: run/literal extremes, end on header, low byte, mid-literal, complete token
    foreach (directed[i]) begin
      feed_byte(directed[i][7:0], directed[i][8]);
    end
    drain();

    bytes_fed = 0;
    while (bytes_fed < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        feed_token(TokOpen);
      end else if (pick < 75) begin
        feed_token(TokClose);
      end else if (pick < 88) begin
        feed_token(TokCut);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          feed_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
      end
      if ($urandom_range(0, 24) == 0) drain();
    end
    drain();
    repeat (10) @(posedge clk);

    $display("Fed %0d random bytes after the directed set; checked %0d descriptors",
             bytes_fed, runs.n_runs);
    $display("  including %0d image ends, %0d truncations, %0d runs of 128; %0d mismatches",
             runs.n_image_ends, runs.n_truncations, runs.n_max_runs, runs.mismatches);
    if (runs.mismatches == 0 && runs.pending() == 0) begin
      $display("rle_pixel_stream_decoder_tb passed");
    end else begin
      $display("rle_pixel_stream_decoder_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rpsd_pkg.sv
rtl/core/rpsd_front.sv
rtl/core/rpsd_queue.sv
rtl/core/rpsd_back.sv
rtl/core/rle_pixel_stream_decoder.sv
tb/sv/rle_pixel_stream_decoder_tb.sv
